// ===== sv/natprt_pkg.sv =====
// natprt_pkg: shared types and constants of the nat port rebinding table
// no dependencies; used by the controller, the datapath and the checker
`timescale 1ns / 1ps
package natprt_pkg;

  // result status codes
  localparam logic [2:0] ST_OUT_FWD   = 3'd0;
  localparam logic [2:0] ST_IN_FWD    = 3'd1;
  localparam logic [2:0] ST_NO_BIND   = 3'd2;
  localparam logic [2:0] ST_NO_SRC    = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_REBIND    = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_CLIENT   = 2'd0;
  localparam logic [1:0] CFG_SERVER   = 2'd1;
  localparam logic [1:0] CFG_RB_ADDR  = 2'd2;
  localparam logic [1:0] CFG_SEED     = 2'd3;

  localparam logic [31:0] NAT_RESET    = 32'hC1A70064;
  localparam logic [31:0] CLIENT_RESET = 32'hC1A70064;
  localparam logic [31:0] SERVER_RESET = 32'hC1A76464;
  localparam logic [31:0] LFSR_TAPS    = 32'h80200003;
  localparam logic [31:0] HOST_MASK    = 32'hffffff00;
  localparam logic [15:0] HOST_RANGE   = 16'd254;
  localparam logic [15:0] USER_MIN     = 16'd1024;
  localparam logic [15:0] USER_MAX     = 16'd49151;
  localparam logic [15:0] SYS_RANGE    = 16'd1023;
  localparam logic [15:0] USER_RANGE   = 16'd48128;
  localparam logic [15:0] DYN_RANGE    = 16'd16384;
  localparam logic [15:0] DYN_MIN      = 16'd49152;

  // floor(2^32 / range): the estimated quotient is low by at most one
  localparam logic [31:0] HOST_RECIP   = 32'd16909320;
  localparam logic [31:0] SYS_RECIP    = 32'd4198404;
  localparam logic [31:0] USER_RECIP   = 32'd89240;
  localparam logic [31:0] DYN_RECIP    = 32'd262144;
  localparam logic [1:0]  MOD_STEPS    = 2'd3;

  typedef struct packed {
    logic latch;        // capture the input transaction
    logic xlate;        // translate and load the result register
    logic draw_addr;    // step lfsr, start host byte reduction
    logic addr_commit;  // take candidate as new nat address
    logic draw_port;    // step lfsr, start port reduction for current entry
    logic port_commit;  // write candidate as public port of current entry
    logic idx_clear;
    logic idx_inc;
    logic rebind_out;   // load rebind result
  } natprt_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic addr_ok;
    logic port_ok;
    logic entry_valid;
    logic idx_last;
    logic out_free;
    logic rb_addr_en;
  } natprt_sts_t;

endpackage

// ===== sv/nat_port_rebinding_table.sv =====
// nat_port_rebinding_table: top level, controller plus datapath
// depends on natprt_pkg, natprt_ctrl and natprt_dp
`timescale 1ns / 1ps
// udp nat binding table for one inside client and one outside server. a packet
// transaction is captured, then compared in parallel against all ENTRIES
// bindings once the output register is free, and the next one is taken as soon
// as the result is in the output register. a rebind transaction walks the table
// one entry at a time; every random draw passes the remainder unit (reciprocal
// multiply, back-multiply, correcting subtract, done) and then a check state,
// with an extra draw for each candidate that collides. configuration is to be
// written only while no transaction is in flight, by the user; the block
// itself does not enforce this
module nat_port_rebinding_table #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input transactions
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [15:0] src_udp_port,
  input  logic [15:0] dst_udp_port,
  // result transactions
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] out_src_addr,
  output logic [31:0] out_dst_addr,
  output logic [15:0] out_src_port,
  output logic [15:0] out_dst_port,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  natprt_pkg::natprt_cmd_t ctl;
  natprt_pkg::natprt_sts_t sts;

  // state machine decides, datapath holds the table and the lfsr
  natprt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (cmd),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  natprt_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .src_addr     (src_addr),
    .dst_addr     (dst_addr),
    .src_udp_port (src_udp_port),
    .dst_udp_port (dst_udp_port),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .out_src_addr (out_src_addr),
    .out_dst_addr (out_dst_addr),
    .out_src_port (out_src_port),
    .out_dst_port (out_dst_port)
  );

endmodule

// ===== sv/natprt_ctrl.sv =====
// natprt_ctrl: sequencing state machine for translation and rebind walks
// depends on natprt_pkg for the command and status structs
`timescale 1ns / 1ps
module natprt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_cmd,
  output logic                 in_ready,
  input  natprt_pkg::natprt_sts_t sts,
  output natprt_pkg::natprt_cmd_t ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_XLATE  = 3'd1;
  localparam logic [2:0] S_A_WAIT = 3'd2;
  localparam logic [2:0] S_A_CHK  = 3'd3;
  localparam logic [2:0] S_P_SEL  = 3'd4;
  localparam logic [2:0] S_P_WAIT = 3'd5;
  localparam logic [2:0] S_P_CHK  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch = 1'b1;
          if (!in_cmd) begin
            state_next = S_XLATE;
          end else if (sts.rb_addr_en) begin
            ctl.draw_addr = 1'b1;
            state_next    = S_A_WAIT;
          end else begin
            ctl.idx_clear = 1'b1;
            state_next    = S_P_SEL;
          end
        end
      end
      S_XLATE: begin
        if (sts.out_free) begin
          ctl.xlate  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_A_WAIT: begin
        if (sts.mod_done) state_next = S_A_CHK;
      end
      S_A_CHK: begin
        if (sts.addr_ok) begin
          ctl.addr_commit = 1'b1;
          ctl.idx_clear   = 1'b1;
          state_next      = S_P_SEL;
        end else begin
          ctl.draw_addr = 1'b1;
          state_next    = S_A_WAIT;
        end
      end
      S_P_SEL: begin
        if (sts.entry_valid) begin
          ctl.draw_port = 1'b1;
          state_next    = S_P_WAIT;
        end else if (sts.idx_last) begin
          state_next = S_DONE;
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      S_P_WAIT: begin
        if (sts.mod_done) state_next = S_P_CHK;
      end
      S_P_CHK: begin
        if (sts.port_ok) begin
          ctl.port_commit = 1'b1;
          if (sts.idx_last) begin
            state_next = S_DONE;
          end else begin
            ctl.idx_inc = 1'b1;
            state_next  = S_P_SEL;
          end
        end else begin
          ctl.draw_port = 1'b1;
          state_next    = S_P_WAIT;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.rebind_out = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== sv/natprt_dp.sv =====
// natprt_dp: binding table, lfsr, remainder unit, config and result registers
// depends on natprt_pkg; driven by natprt_ctrl
`timescale 1ns / 1ps
module natprt_dp #(
  parameter int ENTRIES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  natprt_pkg::natprt_cmd_t ctl,
  output natprt_pkg::natprt_sts_t sts,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [31:0]          src_addr,
  input  logic [31:0]          dst_addr,
  input  logic [15:0]          src_udp_port,
  input  logic [15:0]          dst_udp_port,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           status,
  output logic [31:0]          out_src_addr,
  output logic [31:0]          out_dst_addr,
  output logic [15:0]          out_src_port,
  output logic [15:0]          out_dst_port
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [31:0] client_addr, server_addr, nat_addr, lfsr;
  logic        rb_addr_en;
  logic [ENTRIES-1:0] bvalid;
  logic [15:0] inside_port [ENTRIES];
  logic [15:0] public_port [ENTRIES];
  logic [IW-1:0] idx;

  logic [31:0] l_src, l_dst;
  logic [15:0] l_sp, l_dp;

  // remainder unit: reciprocal multiply, back-multiply, one correcting subtract
  logic [31:0] mod_src, mod_recip, mod_q;
  logic [15:0] mod_rem, mod_div, mod_lo;
  logic [1:0]  mod_cnt;
  logic [16:0] mod_r;
  logic [63:0] mod_prod;
  logic [31:0] mod_back;
  logic [31:0] lfsr_step;
  logic [15:0] cand;
  logic [31:0] addr_cand;
  logic [15:0] cur_pp;

  assign lfsr_step = {1'b0, lfsr[31:1]} ^ (lfsr[0] ? natprt_pkg::LFSR_TAPS : 32'd0);
  assign mod_prod  = mod_src * mod_recip;
  assign mod_back  = mod_src - 32'(mod_q * {16'd0, mod_div});
  assign cand      = mod_lo + mod_rem;
  assign addr_cand = (nat_addr & natprt_pkg::HOST_MASK) | {24'd0, cand[7:0]};
  assign cur_pp    = public_port[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_cnt <= '0;
    end else if (ctl.draw_addr || ctl.draw_port) begin
      mod_cnt <= natprt_pkg::MOD_STEPS;
    end else if (mod_cnt != 2'd0) begin
      mod_cnt <= mod_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.draw_addr || ctl.draw_port) begin
      mod_src <= lfsr_step;
      if (ctl.draw_addr) begin
        mod_div   <= natprt_pkg::HOST_RANGE;
        mod_recip <= natprt_pkg::HOST_RECIP;
        mod_lo    <= 16'd1;
      end else if (cur_pp < natprt_pkg::USER_MIN) begin
        mod_div   <= natprt_pkg::SYS_RANGE;
        mod_recip <= natprt_pkg::SYS_RECIP;
        mod_lo    <= 16'd1;
      end else if (cur_pp > natprt_pkg::USER_MAX) begin
        mod_div   <= natprt_pkg::DYN_RANGE;
        mod_recip <= natprt_pkg::DYN_RECIP;
        mod_lo    <= natprt_pkg::DYN_MIN;
      end else begin
        mod_div   <= natprt_pkg::USER_RANGE;
        mod_recip <= natprt_pkg::USER_RECIP;
        mod_lo    <= natprt_pkg::USER_MIN;
      end
    end else if (mod_cnt == 2'd3) begin
      // quotient estimate, exact or one short
      mod_q <= mod_prod[63:32];
    end else if (mod_cnt == 2'd2) begin
      // partial remainder below twice the range
      mod_r <= mod_back[16:0];
    end else if (mod_cnt == 2'd1) begin
      mod_rem <= (mod_r >= {1'b0, mod_div}) ? 16'(mod_r - {1'b0, mod_div}) : mod_r[15:0];
    end
  end

  // configuration and lfsr
  always_ff @(posedge clk) begin
    if (rst) begin
      client_addr <= natprt_pkg::CLIENT_RESET;
      server_addr <= natprt_pkg::SERVER_RESET;
      rb_addr_en  <= 1'b0;
      lfsr        <= 32'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        natprt_pkg::CFG_CLIENT:  client_addr <= cfg_data;
        natprt_pkg::CFG_SERVER:  server_addr <= cfg_data;
        natprt_pkg::CFG_RB_ADDR: rb_addr_en  <= cfg_data[0];
        natprt_pkg::CFG_SEED:    lfsr <= (cfg_data == 32'd0) ? 32'd1 : cfg_data;
        default: ;
      endcase
    end else if (ctl.draw_addr || ctl.draw_port) begin
      lfsr <= lfsr_step;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      l_src <= src_addr;
      l_dst <= dst_addr;
      l_sp  <= src_udp_port;
      l_dp  <= dst_udp_port;
    end
  end

  // table lookups: lowest index wins
  logic          out_hit, free_hit, in_hit;
  logic [IW-1:0] out_idx, free_idx, in_idx;
  logic          port_clash;

  always_comb begin
    out_hit = 1'b0; free_hit = 1'b0; in_hit = 1'b0;
    out_idx = '0; free_idx = '0; in_idx = '0;
    port_clash = (cand == cur_pp);
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (bvalid[i] && inside_port[i] == l_sp) begin
        out_hit = 1'b1; out_idx = IW'(i);
      end
      if (!bvalid[i]) begin
        free_hit = 1'b1; free_idx = IW'(i);
      end
      if (bvalid[i] && public_port[i] == l_dp) begin
        in_hit = 1'b1; in_idx = IW'(i);
      end
      if (bvalid[i] && IW'(i) != idx && public_port[i] == cand) port_clash = 1'b1;
    end
  end

  logic is_client, is_server;
  assign is_client = (l_src == client_addr);
  assign is_server = (l_src == server_addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      nat_addr <= natprt_pkg::NAT_RESET;
      bvalid   <= '0;
      idx      <= '0;
    end else begin
      if (ctl.addr_commit) nat_addr <= addr_cand;
      if (ctl.xlate && is_client && !out_hit && free_hit) bvalid[free_idx] <= 1'b1;
      if (ctl.idx_clear) idx <= '0;
      else if (ctl.idx_inc) idx <= idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.xlate && is_client && !out_hit && free_hit) begin
      inside_port[free_idx] <= l_sp;
      public_port[free_idx] <= l_sp;
    end else if (ctl.port_commit) begin
      public_port[idx] <= cand;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.xlate || ctl.rebind_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rebind_out) begin
      status       <= natprt_pkg::ST_REBIND;
      out_src_addr <= nat_addr;
      out_dst_addr <= '0;
      out_src_port <= '0;
      out_dst_port <= '0;
    end else if (ctl.xlate) begin
      status       <= natprt_pkg::ST_NO_SRC;
      out_src_addr <= '0;
      out_dst_addr <= '0;
      out_src_port <= '0;
      out_dst_port <= '0;
      if (is_client) begin
        if (out_hit || free_hit) begin
          status       <= natprt_pkg::ST_OUT_FWD;
          out_src_addr <= nat_addr;
          out_dst_addr <= l_dst;
          out_src_port <= out_hit ? public_port[out_idx] : l_sp;
          out_dst_port <= l_dp;
        end else begin
          status <= natprt_pkg::ST_FULL;
        end
      end else if (is_server) begin
        if (in_hit) begin
          status       <= natprt_pkg::ST_IN_FWD;
          out_src_addr <= l_src;
          out_dst_addr <= client_addr;
          out_src_port <= l_sp;
          out_dst_port <= inside_port[in_idx];
        end else begin
          status <= natprt_pkg::ST_NO_BIND;
        end
      end
    end
  end

  assign sts.mod_done    = (mod_cnt == 2'd0);
  assign sts.addr_ok     = (addr_cand != nat_addr) && (addr_cand != client_addr);
  assign sts.port_ok     = !port_clash;
  assign sts.entry_valid = bvalid[idx];
  assign sts.idx_last    = (idx == IW'(ENTRIES - 1));
  assign sts.out_free    = !out_valid || out_ready;
  assign sts.rb_addr_en  = rb_addr_en;

endmodule

// ===== sv/natprt_chk.sv =====
// natprt_chk: port-level checks on the nat port rebinding table
// depends on natprt_pkg; bound to nat_port_rebinding_table below
`timescale 1ns / 1ps
module natprt_chk (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [31:0] out_src_addr,
  input logic [31:0] out_dst_addr,
  input logic [15:0] out_src_port,
  input logic [15:0] out_dst_port
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_src_addr))
    else $error("stalled result changed");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= natprt_pkg::ST_REBIND)
    else $error("status code out of range");

  a_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == natprt_pkg::ST_NO_BIND || status == natprt_pkg::ST_NO_SRC ||
                  status == natprt_pkg::ST_FULL)
    |-> out_src_addr == 32'd0 && out_dst_addr == 32'd0 &&
        out_src_port == 16'd0 && out_dst_port == 16'd0)
    else $error("dropped packet carries data");

  a_rebind: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == natprt_pkg::ST_REBIND
    |-> out_dst_addr == 32'd0 && out_src_port == 16'd0 && out_dst_port == 16'd0)
    else $error("rebind result carries packet fields");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind nat_port_rebinding_table natprt_chk u_natprt_chk (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .out_src_addr (out_src_addr),
  .out_dst_addr (out_dst_addr),
  .out_src_port (out_src_port),
  .out_dst_port (out_dst_port)
);

// ===== bench/testbench.sv =====
// testbench: self-checking bench for the nat port rebinding table
// depends on natprt_pkg and nat_port_rebinding_table
`timescale 1ns / 1ps
module testbench;

  localparam int ENTRIES = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = 1'b0;
  logic [31:0] src_addr = '0;
  logic [31:0] dst_addr = '0;
  logic [15:0] src_udp_port = '0;
  logic [15:0] dst_udp_port = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [31:0] out_src_addr;
  logic [31:0] out_dst_addr;
  logic [15:0] out_src_port;
  logic [15:0] out_dst_port;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  nat_port_rebinding_table #(.ENTRIES(ENTRIES)) dut (.*);

  always #5 clk = ~clk;

  // one packet or command transaction
  typedef struct packed {
    logic        cmd;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
  } pkt_t;

  // one translated result
  typedef struct packed {
    logic [2:0]  st;
    logic [31:0] osa;
    logic [31:0] oda;
    logic [15:0] osp;
    logic [15:0] odp;
  } xlat_t;

  // directed row: the packet plus an optional typed-in result
  typedef struct packed {
    pkt_t  p;
    logic  fixed;
    xlat_t r;
  } row_t;

  // shadow of the block's state and configuration
  logic [31:0] m_client, m_server, m_nat, m_lfsr;
  logic        m_rb_addr;
  logic        m_valid [ENTRIES];
  logic [15:0] m_inside [ENTRIES];
  logic [15:0] m_public [ENTRIES];

  xlat_t pending_results[$];
  int    mismatches = 0;
  int    sender_idle = 0, receiver_stall = 0;

  // one lfsr step, then a value in [lo,hi]
  function automatic logic [31:0] lfsr_draw(logic [31:0] lo, logic [31:0] hi);
    logic outbit;
    outbit = m_lfsr[0];
    m_lfsr = m_lfsr >> 1;
    if (outbit) m_lfsr = m_lfsr ^ natprt_pkg::LFSR_TAPS;
    return lo + m_lfsr % (hi - lo + 32'd1);
  endfunction

  function automatic bit port_in_use(int self, logic [31:0] port);
    if (port == {16'd0, m_public[self]}) return 1;
    for (int i = 0; i < ENTRIES; i++)
      if (i != self && m_valid[i] && {16'd0, m_public[i]} == port) return 1;
    return 0;
  endfunction

  // renew every binding's public port within its scope, and the nat address if enabled
  task automatic rebind_bindings();
    logic [31:0] old_nat, cand, lo, hi;
    if (m_rb_addr) begin
      old_nat = m_nat;
      do begin
        cand = (old_nat & natprt_pkg::HOST_MASK) | lfsr_draw(32'd1, 32'hfe);
      end while (cand == old_nat || cand == m_client);
      m_nat = cand;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (!m_valid[i]) continue;
      if (m_public[i] < natprt_pkg::USER_MIN) begin
        lo = 1; hi = 1023;
      end else if (m_public[i] > natprt_pkg::USER_MAX) begin
        lo = 49152; hi = 65535;
      end else begin
        lo = 1024; hi = 49151;
      end
      do cand = lfsr_draw(lo, hi); while (port_in_use(i, cand));
      m_public[i] = cand[15:0];
    end
  endtask

  task automatic translate_packet(input pkt_t p, output xlat_t r);
    int hit, slot;
    hit = -1;
    slot = -1;
    r = '0;
    if (p.cmd) begin
      rebind_bindings();
      r.st = natprt_pkg::ST_REBIND;
      r.osa = m_nat;
    end else if (p.src == m_client) begin
      for (int i = 0; i < ENTRIES && hit < 0; i++)
        if (m_valid[i] && m_inside[i] == p.sport) hit = i;
      if (hit < 0) begin
        for (int i = 0; i < ENTRIES && slot < 0; i++)
          if (!m_valid[i]) slot = i;
        if (slot >= 0) begin
          m_valid[slot] = 1;
          m_inside[slot] = p.sport;
          m_public[slot] = p.sport;
          hit = slot;
        end
      end
      if (hit < 0) r.st = natprt_pkg::ST_FULL;
      else begin
        r.st = natprt_pkg::ST_OUT_FWD;
        r.osa = m_nat;
        r.oda = p.dst;
        r.osp = m_public[hit];
        r.odp = p.dport;
      end
    end else if (p.src == m_server) begin
      for (int i = 0; i < ENTRIES && hit < 0; i++)
        if (m_valid[i] && m_public[i] == p.dport) hit = i;
      if (hit < 0) r.st = natprt_pkg::ST_NO_BIND;
      else begin
        r.st = natprt_pkg::ST_IN_FWD;
        r.osa = p.src;
        r.oda = m_client;
        r.osp = p.sport;
        r.odp = m_inside[hit];
      end
    end else begin
      r.st = natprt_pkg::ST_NO_SRC;
    end
  endtask

  // one write, then the configuration port is left quiet before returning
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      natprt_pkg::CFG_CLIENT:  m_client = val;
      natprt_pkg::CFG_SERVER:  m_server = val;
      natprt_pkg::CFG_RB_ADDR: m_rb_addr = val[0];
      natprt_pkg::CFG_SEED:    m_lfsr = (val == 0) ? 32'd1 : val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // drop valid, wait for the result queue to drain, plus a margin
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // send one transaction; the expectation is queued at acceptance
  task automatic send_packet(pkt_t p, bit fixed = 0, xlat_t want = '0);
    xlat_t r;
    if (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle);
    end
    in_valid <= 1'b1;
    cmd <= p.cmd;
    src_addr <= p.src;
    dst_addr <= p.dst;
    src_udp_port <= p.sport;
    dst_udp_port <= p.dport;
    do @(posedge clk); while (!in_ready);
    translate_packet(p, r);
    if (fixed && r != want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed row disagrees with predictor: table %h predictor %h", want, r);
    end
    pending_results.push_back(fixed ? want : r);
  endtask

  // receiver side: random stalls, compare on each accepted result
  always @(posedge clk) begin
    xlat_t got, exp_r;
    if (rst) out_ready <= 1'b0;
    else begin
      if (out_valid && out_ready) begin
        got = '{status, out_src_addr, out_dst_addr, out_src_port, out_dst_port};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          exp_r = pending_results.pop_front();
          if (got.st !== exp_r.st || got.osa !== exp_r.osa || got.oda !== exp_r.oda ||
              got.osp !== exp_r.osp || got.odp !== exp_r.odp) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %h actual %h", exp_r, got);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_stall);
    end
  end

  // random packet, mostly from client or server to hit real bindings
  function automatic pkt_t random_packet();
    pkt_t p;
    int k;
    p.cmd = ($urandom_range(99) < 4);
    p.dst = $urandom;
    p.sport = 16'($urandom);
    p.dport = 16'($urandom);
    k = $urandom_range(99);
    if (k < 45) begin
      p.src = m_client;
      if ($urandom_range(3) != 0) p.sport = 16'(32'd1000 + $urandom_range(20) * 32'd2400);
    end else if (k < 90) begin
      p.src = m_server;
      k = $urandom_range(ENTRIES - 1);
      if (m_valid[k] && $urandom_range(3) != 0) p.dport = m_public[k];
    end else p.src = $urandom;
    return p;
  endfunction

  row_t rows[$];

  initial begin
    pkt_t p;
    m_client = natprt_pkg::CLIENT_RESET;
    m_server = natprt_pkg::SERVER_RESET;
    m_nat = natprt_pkg::NAT_RESET;
    m_rb_addr = 0;
    m_lfsr = 32'd1;
    for (int i = 0; i < ENTRIES; i++) begin
      m_valid[i] = 0; m_inside[i] = 0; m_public[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table; fixed rows have results readable at a glance
    rows.push_back('{'{1'b0, natprt_pkg::SERVER_RESET, 32'h0, 16'h1, 16'h50}, 1'b1,
                     '{natprt_pkg::ST_NO_BIND, 32'h0, 32'h0, 16'h0, 16'h0}});
    rows.push_back('{'{1'b0, 32'h0, 32'hffffffff, 16'hffff, 16'hffff}, 1'b1,
                     '{natprt_pkg::ST_NO_SRC, 32'h0, 32'h0, 16'h0, 16'h0}});
    rows.push_back('{'{1'b0, 32'hffffffff, 32'h0, 16'h0, 16'h0}, 1'b1,
                     '{natprt_pkg::ST_NO_SRC, 32'h0, 32'h0, 16'h0, 16'h0}});
    rows.push_back('{'{1'b0, natprt_pkg::CLIENT_RESET, 32'hffffffff, 16'h0, 16'hffff}, 1'b1,
                     '{natprt_pkg::ST_OUT_FWD, natprt_pkg::NAT_RESET, 32'hffffffff,
                       16'h0, 16'hffff}});
    rows.push_back('{'{1'b0, natprt_pkg::CLIENT_RESET, 32'h0, 16'hffff, 16'h0}, 1'b1,
                     '{natprt_pkg::ST_OUT_FWD, natprt_pkg::NAT_RESET, 32'h0,
                       16'hffff, 16'h0}});
    rows.push_back('{'{1'b0, natprt_pkg::SERVER_RESET, 32'h1, 16'h1234, 16'hffff}, 1'b1,
                     '{natprt_pkg::ST_IN_FWD, natprt_pkg::SERVER_RESET,
                       natprt_pkg::CLIENT_RESET, 16'h1234, 16'hffff}});
    rows.push_back('{'{1'b0, natprt_pkg::CLIENT_RESET, 32'h5, 16'd1023, 16'h7}, 1'b0, '0});
    rows.push_back('{'{1'b0, natprt_pkg::CLIENT_RESET, 32'h5, 16'd1024, 16'h7}, 1'b0, '0});
    rows.push_back('{'{1'b0, natprt_pkg::CLIENT_RESET, 32'h5, 16'd49151, 16'h7}, 1'b0, '0});
    rows.push_back('{'{1'b0, natprt_pkg::CLIENT_RESET, 32'h5, 16'd49152, 16'h7}, 1'b0, '0});
    rows.push_back('{'{1'b1, 32'h0, 32'h0, 16'h0, 16'h0}, 1'b0, '0});
    // old public port no longer reaches the client after a rebind
    rows.push_back('{'{1'b0, natprt_pkg::SERVER_RESET, 32'h0, 16'h9, 16'd1023}, 1'b0, '0});
    rows.push_back('{'{1'b0, natprt_pkg::CLIENT_RESET, 32'h0, 16'd1023, 16'h9}, 1'b0, '0});
    foreach (rows[i]) send_packet(rows[i].p, rows[i].fixed, rows[i].r);
    drain();

    // fill the table so the full case is reached, then rebind with address
    write_reg(natprt_pkg::CFG_RB_ADDR, 32'h1);
    write_reg(natprt_pkg::CFG_SEED, 32'h0);
    for (int i = 0; i < ENTRIES + 2; i++)
      send_packet('{1'b0, m_client, 32'h0, 16'd60000 + i[15:0], 16'h1});
    send_packet('{1'b1, 32'h0, 32'h0, 16'h0, 16'h0});
    send_packet('{1'b1, 32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff});
    drain();

    // random phases over settings and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin sender_idle = 0;  receiver_stall = 0;  end
        1: begin sender_idle = 88; receiver_stall = 0;  end
        2: begin sender_idle = 0;  receiver_stall = 88; end
        3: begin sender_idle = 31; receiver_stall = 31; end
        4: begin sender_idle = 0;  receiver_stall = 0;  end
        default: begin sender_idle = 31; receiver_stall = 31; end
      endcase
      // client equals server on one phase, extremes on others
      write_reg(natprt_pkg::CFG_CLIENT,
                (ph == 2) ? 32'hffffffff : (ph == 3) ? 32'h0 : $urandom);
      write_reg(natprt_pkg::CFG_SERVER,
                (ph == 4) ? m_client : (ph == 5) ? 32'hffffffff : $urandom);
      write_reg(natprt_pkg::CFG_RB_ADDR, {31'd0, ph[0]});
      write_reg(natprt_pkg::CFG_SEED,
                (ph == 1) ? 32'hffffffff : $urandom_range(32'hffffffff, 1));
      for (int n = 0; n < 270; n++) begin
        p = random_packet();
        send_packet(p);
        // hold off once until everything has come back
        if (ph == 0 && n == 100) drain();
      end
      drain();
    end

    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
